// File: design/lsc_pkg.sv
// Shared types, codes and constants for the line sensor conditioner.
// Used by lsc_channel and line_sensor_conditioner; depends on nothing else.
package lsc_pkg;

	localparam int SampleW = 10;
	localparam int LevelW  = 18;   // Q10.8 running average
	localparam int AlphaW  = 9;    // Q1.8, 256 means one
	localparam int EchoW   = 15;
	localparam int DistW   = 10;
	localparam int CfgIdxW = 8;
	localparam int CfgW    = 10;

	localparam logic [AlphaW-1:0] AlphaOne = 9'd256;

	// floor(x / 58) as (x * 36158) >> 21; exact for every 15-bit x.
	localparam logic [15:0] Div58Recip = 16'd36158;
	localparam int          Div58Shift = 21;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ALPHA      = 8'd0,
		CFG_ENTER      = 8'd1,
		CFG_LEAVE      = 8'd2,
		CFG_OBST_LIMIT = 8'd3
	} cfg_index_t;

	localparam logic [AlphaW-1:0]  AlphaReset      = 9'd77;
	localparam logic [SampleW-1:0] EnterReset      = 10'd300;
	localparam logic [SampleW-1:0] LeaveReset      = 10'd600;
	localparam logic [DistW-1:0]   ObstLimitReset  = 10'd10;

	typedef enum logic [2:0] {
		DRIVE_STOP         = 3'd0,
		DRIVE_INTERSECTION = 3'd1,
		DRIVE_LEFT         = 3'd2,
		DRIVE_RIGHT        = 3'd3,
		DRIVE_FOLLOW       = 3'd4,
		DRIVE_END          = 3'd5
	} drive_t;

	typedef struct packed {
		logic [SampleW-1:0] left_sample;
		logic [SampleW-1:0] middle_sample;
		logic [SampleW-1:0] right_sample;
		logic [EchoW-1:0]   echo_us;
	} in_item_t;

	typedef struct packed {
		logic             left_on_line;
		logic             middle_on_line;
		logic             right_on_line;
		logic             obstacle_seen;
		logic [DistW-1:0] distance_cm;
		logic             distance_valid;
		drive_t           drive_state;
	} out_item_t;

	// Settings shared by the three reflectance channels.
	typedef struct packed {
		logic [AlphaW-1:0]  alpha;      // already limited to one
		logic [AlphaW-1:0]  alpha_inv;  // one minus alpha
		logic [SampleW-1:0] enter_level;
		logic [SampleW-1:0] leave_level;
	} chan_cfg_t;

endpackage

// File: design/lsc_channel.sv
// One reflectance channel: exponential average and on-line hysteresis flag.
// Depends on lsc_pkg.
module lsc_channel (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsc_pkg::chan_cfg_t       cfg,
	input  logic [lsc_pkg::SampleW-1:0] sample,
	input  logic                     commit,
	output logic                     on_line
);
	import lsc_pkg::*;

	logic [LevelW-1:0]  level_q;
	logic               primed_q;
	logic               flag_q;
	logic [18:0]        new_term;
	logic [26:0]        hold_term;
	logic [19:0]        ema_sum;
	logic [LevelW-1:0]  level_next;
	logic [LevelW-1:0]  enter_thr;
	logic [LevelW-1:0]  leave_thr;

	// The new sample enters as alpha * sample * 256, so after the shift by eight
	// only the old-average term carries a fraction to drop.
	assign new_term  = 19'(cfg.alpha) * 19'(sample);
	assign hold_term = 27'(cfg.alpha_inv) * 27'(level_q);
	assign ema_sum   = 20'(new_term) + 20'(hold_term[26:8]);

	assign level_next = primed_q ? ema_sum[LevelW-1:0] : {sample, 8'd0};
	assign enter_thr  = {cfg.enter_level, 8'd0};
	assign leave_thr  = {cfg.leave_level, 8'd0};

	always_comb begin
		if (flag_q) begin
			on_line = !(level_next > leave_thr);
		end else begin
			on_line = level_next < enter_thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			primed_q <= 1'b0;
			flag_q   <= 1'b0;
		end else if (commit) begin
			level_q  <= level_next;
			primed_q <= 1'b1;
			flag_q   <= on_line;
		end
	end

endmodule

// File: design/line_sensor_conditioner.sv
// Top level of the line sensor conditioner: input and result registers,
// echo distance, obstacle flag and drive decode. Depends on lsc_pkg, lsc_channel.
//
// Usage:
//   Input channel in_valid/in_ready/in_item carries three reflectance samples
//   and one echo time. Result channel out_valid/out_ready/out_item returns one
//   result per input transfer, in order.
//   An accepted item is held in the input register, where the channel
//   averages, hysteresis, the divide by 58 and the drive decode are worked out
//   in one pass; the result then moves into the output register, which raises
//   out_valid, once that register is free or out_ready is high. One item per
//   cycle is sustained while out_ready stays high.
//   When the receiver stalls, the result waits in the output register and one
//   more item may be taken into the input register; in_ready then drops until
//   the result transfer frees a slot. Channel state is only updated when an
//   item moves into the output register.
//   Reset clears the averages, primed and line flags and the obstacle flag,
//   and loads the register defaults (alpha 77, enter 300, leave 600, limit 10).
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
module line_sensor_conditioner (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lsc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [lsc_pkg::CfgW-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lsc_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lsc_pkg::out_item_t          out_item
);
	import lsc_pkg::*;

	logic [AlphaW-1:0]  alpha_q;
	logic [SampleW-1:0] enter_q;
	logic [SampleW-1:0] leave_q;
	logic [DistW-1:0]   obst_limit_q;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_item_q;
	logic      out_valid_q;
	logic      obstacle_q;

	logic      advance;
	chan_cfg_t chan_cfg;
	logic      left_on, middle_on, right_on;
	logic [30:0]      echo_prod;
	logic [DistW-1:0] dist_cm;
	logic             dist_valid;
	logic             obstacle_next;
	drive_t           drive;
	out_item_t        result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= AlphaReset;
			enter_q      <= EnterReset;
			leave_q      <= LeaveReset;
			obst_limit_q <= ObstLimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:      alpha_q      <= cfg_data[AlphaW-1:0];
				CFG_ENTER:      enter_q      <= cfg_data[SampleW-1:0];
				CFG_LEAVE:      leave_q      <= cfg_data[SampleW-1:0];
				CFG_OBST_LIMIT: obst_limit_q <= cfg_data[DistW-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		chan_cfg.alpha       = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
		chan_cfg.alpha_inv   = AlphaOne - chan_cfg.alpha;
		chan_cfg.enter_level = enter_q;
		chan_cfg.leave_level = leave_q;
	end

	lsc_channel u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (chan_cfg),
		.sample  (item_s1.left_sample),
		.commit  (advance),
		.on_line (left_on)
	);

	lsc_channel u_middle (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (chan_cfg),
		.sample  (item_s1.middle_sample),
		.commit  (advance),
		.on_line (middle_on)
	);

	lsc_channel u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (chan_cfg),
		.sample  (item_s1.right_sample),
		.commit  (advance),
		.on_line (right_on)
	);

	// Divide by 58 through a reciprocal multiply; no echo reports zero distance.
	assign echo_prod     = 31'(item_s1.echo_us) * 31'(Div58Recip);
	assign dist_valid    = item_s1.echo_us != '0;
	assign dist_cm       = dist_valid ? echo_prod[Div58Shift+DistW-1:Div58Shift] : '0;
	assign obstacle_next = dist_valid ? (dist_cm <= obst_limit_q) : obstacle_q;

	always_comb begin
		if (obstacle_next) begin
			drive = DRIVE_STOP;
		end else begin
			case ({left_on, middle_on, right_on}) inside
				3'b111, 3'b110, 3'b011: drive = DRIVE_INTERSECTION;
				3'b100:                 drive = DRIVE_LEFT;
				3'b001:                 drive = DRIVE_RIGHT;
				3'b010, 3'b101:         drive = DRIVE_FOLLOW;
				default:                drive = DRIVE_END;
			endcase
		end
	end

	always_comb begin
		result.left_on_line   = left_on;
		result.middle_on_line = middle_on;
		result.right_on_line  = right_on;
		result.obstacle_seen  = obstacle_next;
		result.distance_cm    = dist_cm;
		result.distance_valid = dist_valid;
		result.drive_state    = drive;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			obstacle_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				obstacle_q  <= obstacle_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
